// ----- rtl/lmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// lmtc_pkg
// Shared types and constants for the lcd mode timing controller: line timing
// limits, status source bits, mode codes and the result record.
// ----------------------------------------------------------------------------
package lmtc_pkg;

    localparam int DOT_W  = 10;
    localparam int LINE_W = 8;
    localparam int TICK_W = 8;
    localparam int STAT_W = 8;

    localparam logic [DOT_W-1:0]  DOTS_PER_LINE = DOT_W'(456);
    localparam logic [DOT_W-1:0]  OAM_END       = DOT_W'(80);
    localparam logic [DOT_W-1:0]  XFER_END      = DOT_W'(253);
    localparam logic [LINE_W-1:0] VBLANK_FIRST  = LINE_W'(144);
    localparam logic [LINE_W-1:0] LINE_WRAP     = LINE_W'(153);

    localparam logic [STAT_W-1:0] SRC_HBLANK = 8'b0000_1000;
    localparam logic [STAT_W-1:0] SRC_VBLANK = 8'b0001_0000;
    localparam logic [STAT_W-1:0] SRC_OAM    = 8'b0010_0000;
    localparam logic [STAT_W-1:0] KEEP_MASK  = 8'b0000_0100;

    localparam logic LCD_ENABLE_RESET = 1'b1;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        mode_t             mode;
        logic [STAT_W-1:0] status_byte;
        logic              vram_open;
        logic              oam_open;
        logic              vblank_irq;
        logic              stat_irq;
        logic              render_start;
        logic              frame_done;
    } result_t;

endpackage

// ----- rtl/lcd_mode_timing_controller.sv -----
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller
// Scan line mode sequencer: turns dot-count ticks into line, mode, status and
// access flags with interrupt and render pulses.
// ----------------------------------------------------------------------------
// Each accepted tick is held in an input register; its result moves to the
// output register once that is free; one tick is taken every cycle while
// the output side keeps up, and a waiting result blocks a new tick only once
// the input register is also full. The mode logic between the two registers
// is one add of the dot count and a few compares against the line limits.
// lcd_enable is written through the cfg port (always ready) and should change
// only while no tick is in flight.
module lcd_mode_timing_controller
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        lcd_enable,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lmtc_pkg::TICK_W-1:0] elapsed_dots,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lmtc_pkg::LINE_W-1:0] line_number,
    output logic [1:0]                  mode,
    output logic [lmtc_pkg::STAT_W-1:0] status_byte,
    output logic                        vram_open,
    output logic                        oam_open,
    output logic                        vblank_irq,
    output logic                        stat_irq,
    output logic                        render_start,
    output logic                        frame_done
);

    logic                        s1_valid_reg;
    logic [lmtc_pkg::TICK_W-1:0] dots_reg;
    logic                        s2_valid_reg;
    lmtc_pkg::result_t           res_reg;
    lmtc_pkg::result_t           res_next;
    logic                        s1_move;
    logic                        in_fire;

    assign cfg_ready = 1'b1;
    assign s1_move   = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_fire   = in_valid && !in_stall;

    lmtc_mode_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_move),
        .dots       (dots_reg),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_enable (lcd_enable),
        .res        (res_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dots_reg <= elapsed_dots;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign line_number  = res_reg.line_number;
    assign mode         = res_reg.mode;
    assign status_byte  = res_reg.status_byte;
    assign vram_open    = res_reg.vram_open;
    assign oam_open     = res_reg.oam_open;
    assign vblank_irq   = res_reg.vblank_irq;
    assign stat_irq     = res_reg.stat_irq;
    assign render_start = res_reg.render_start;
    assign frame_done   = res_reg.frame_done;

    a_render_in_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && render_start |-> stat_irq && mode == lmtc_pkg::MODE_XFER)
        else $error("render start outside transfer entry");

    a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_irq |-> stat_irq && mode == lmtc_pkg::MODE_VBLANK)
        else $error("vblank pulse without vblank entry");

    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> line_number == '0 && mode == lmtc_pkg::MODE_VBLANK)
        else $error("frame done with nonzero line");

    a_vram_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vram_open |-> mode == lmtc_pkg::MODE_XFER && !oam_open)
        else $error("vram closed outside transfer");

    a_oam_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !oam_open |-> mode == lmtc_pkg::MODE_OAM || mode == lmtc_pkg::MODE_XFER)
        else $error("oam closed outside oam search or transfer");

endmodule

// ----- rtl/lmtc_mode_seq.sv -----
// ----------------------------------------------------------------------------
// lmtc_mode_seq
// Line timing state (dot counter, line, status, access flags, enable) and the
// single-pass next-state logic that sequences the modes for one tick.
// ----------------------------------------------------------------------------
module lmtc_mode_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lmtc_pkg::TICK_W-1:0]   dots,
    input  logic                          cfg_we,
    input  logic                          cfg_enable,
    output lmtc_pkg::result_t             res
);

    logic [lmtc_pkg::DOT_W-1:0]  dot_counter_reg, dot_counter_next;
    logic [lmtc_pkg::LINE_W-1:0] line_reg, line_next;
    logic [lmtc_pkg::STAT_W-1:0] status_reg, status_next;
    logic                        vram_reg, vram_next;
    logic                        oam_reg, oam_next;
    logic                        enable_reg;

    logic [lmtc_pkg::DOT_W-1:0]  sum;
    logic [lmtc_pkg::LINE_W-1:0] line_adv;
    lmtc_pkg::mode_t             cur_mode;
    logic                        vb, st, rs, fd;

    assign sum      = dot_counter_reg + {{(lmtc_pkg::DOT_W-lmtc_pkg::TICK_W){1'b0}}, dots};
    assign cur_mode = lmtc_pkg::mode_t'(status_reg[1:0]);

    always_comb
    begin
        dot_counter_next = dot_counter_reg;
        line_next        = line_reg;
        status_next      = status_reg;
        vram_next        = vram_reg;
        oam_next         = oam_reg;
        line_adv         = line_reg;
        vb               = 1'b0;
        st               = 1'b0;
        rs               = 1'b0;
        fd               = 1'b0;
        if (enable_reg)
        begin
            dot_counter_next = sum;
            if (line_reg >= lmtc_pkg::VBLANK_FIRST)
            begin
                if (cur_mode != lmtc_pkg::MODE_VBLANK)
                begin
                    status_next = (status_reg & lmtc_pkg::KEEP_MASK)
                                | {6'b0, lmtc_pkg::MODE_VBLANK} | lmtc_pkg::SRC_VBLANK;
                    vram_next   = 1'b1;
                    oam_next    = 1'b1;
                    vb          = 1'b1;
                    st          = 1'b1;
                end
                if (sum >= lmtc_pkg::DOTS_PER_LINE)
                begin
                    dot_counter_next = sum - lmtc_pkg::DOTS_PER_LINE;
                    line_adv         = line_reg + 8'd1;
                end
                line_next = line_adv;
                if (line_adv == lmtc_pkg::LINE_WRAP)
                begin
                    line_next = '0;
                    fd        = 1'b1;
                end
            end
            else if (sum < lmtc_pkg::OAM_END)
            begin
                if (cur_mode != lmtc_pkg::MODE_OAM)
                begin
                    status_next = (status_reg & lmtc_pkg::KEEP_MASK)
                                | {6'b0, lmtc_pkg::MODE_OAM} | lmtc_pkg::SRC_OAM;
                    vram_next   = 1'b1;
                    oam_next    = 1'b0;
                    st          = 1'b1;
                end
            end
            else if (sum < lmtc_pkg::XFER_END)
            begin
                if (cur_mode != lmtc_pkg::MODE_XFER)
                begin
                    status_next = (status_reg & lmtc_pkg::KEEP_MASK)
                                | {6'b0, lmtc_pkg::MODE_XFER} | lmtc_pkg::SRC_HBLANK;
                    vram_next   = 1'b0;
                    oam_next    = 1'b0;
                    st          = 1'b1;
                    rs          = 1'b1;
                end
            end
            else if (sum < lmtc_pkg::DOTS_PER_LINE)
            begin
                if (cur_mode != lmtc_pkg::MODE_HBLANK)
                begin
                    status_next = (status_reg & lmtc_pkg::KEEP_MASK)
                                | {6'b0, lmtc_pkg::MODE_HBLANK} | lmtc_pkg::SRC_HBLANK;
                    vram_next   = 1'b1;
                    oam_next    = 1'b1;
                    st          = 1'b1;
                end
            end
            else
            begin
                // visible line wrap, no mode entry
                dot_counter_next = sum - lmtc_pkg::DOTS_PER_LINE;
                line_next        = line_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_counter_reg <= '0;
            line_reg        <= '0;
            status_reg      <= '0;
            vram_reg        <= 1'b1;
            oam_reg         <= 1'b1;
            enable_reg      <= lmtc_pkg::LCD_ENABLE_RESET;
        end
        else
        begin
            if (step)
            begin
                dot_counter_reg <= dot_counter_next;
                line_reg        <= line_next;
                status_reg      <= status_next;
                vram_reg        <= vram_next;
                oam_reg         <= oam_next;
            end
            if (cfg_we)
            begin
                enable_reg <= cfg_enable;
            end
        end
    end

    always_comb
    begin
        res.line_number  = line_next;
        res.mode         = lmtc_pkg::mode_t'(status_next[1:0]);
        res.status_byte  = status_next;
        res.vram_open    = vram_next;
        res.oam_open     = oam_next;
        res.vblank_irq   = vb;
        res.stat_irq     = st;
        res.render_start = rs;
        res.frame_done   = fd;
    end

endmodule

// ----- dv/lcd_mode_timing_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller_tb
// Feeds dot-count ticks through the scan line sequencer, predicts the line,
// mode, status byte, access flags and pulses of every result, and compares
// them in order. Runs a directed walk across the line boundaries with the
// display on and off, then random ticks biased toward large counts so that
// several frames wrap, under four sender and receiver idling phases.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_tb;

    localparam int DRAIN_SETTLE   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_TICKS    = 220;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ENABLE,
        OP_DRAIN,
        OP_PACE
    } plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        logic [7:0]  dots;
        logic        enable;
        int unsigned idle_pct;
        int unsigned stall_pct;
    } plan_op_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_enable = 1'b1;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [lmtc_pkg::TICK_W-1:0] elapsed_dots = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [lmtc_pkg::LINE_W-1:0] line_number;
    logic [1:0]                  mode;
    logic [lmtc_pkg::STAT_W-1:0] status_byte;
    logic                        vram_open;
    logic                        oam_open;
    logic                        vblank_irq;
    logic                        stat_irq;
    logic                        render_start;
    logic                        frame_done;

    plan_op_t          tick_plan[$];
    lmtc_pkg::result_t scan_results_due[$];
    logic              in_taken = 1'b0;
    logic              cfg_taken = 1'b0;
    int unsigned       idle_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       settle_left = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       mismatches = 0;
    int unsigned       n_ticks = 0;
    int unsigned       n_results = 0;
    int unsigned       n_dark = 0;
    int unsigned       n_frames = 0;
    int unsigned       n_vblank = 0;
    int unsigned       n_render = 0;

    // predicted sequencer state
    logic                        display_on = lmtc_pkg::LCD_ENABLE_RESET;
    logic [lmtc_pkg::DOT_W-1:0]  dot_cnt = '0;
    logic [lmtc_pkg::LINE_W-1:0] scan_line = '0;
    logic [lmtc_pkg::STAT_W-1:0] stat_bits = '0;
    logic                        vram_ok = 1'b1;
    logic                        oam_ok = 1'b1;

    lcd_mode_timing_controller uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .lcd_enable   (cfg_enable),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .elapsed_dots (elapsed_dots),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_number  (line_number),
        .mode         (mode),
        .status_byte  (status_byte),
        .vram_open    (vram_open),
        .oam_open     (oam_open),
        .vblank_irq   (vblank_irq),
        .stat_irq     (stat_irq),
        .render_start (render_start),
        .frame_done   (frame_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void enter_scan_mode(lmtc_pkg::mode_t m,
                                            logic [lmtc_pkg::STAT_W-1:0] src,
                                            logic vram, logic oam);
        vram_ok   = vram;
        oam_ok    = oam;
        stat_bits = (stat_bits & lmtc_pkg::KEEP_MASK) | lmtc_pkg::STAT_W'(m) | src;
    endfunction

    task automatic advance_scan(input logic [lmtc_pkg::TICK_W-1:0] dots,
                                output lmtc_pkg::result_t r);
        lmtc_pkg::mode_t cur;
        r = '0;
        if (display_on)
        begin
            dot_cnt = dot_cnt + lmtc_pkg::DOT_W'(dots);
            cur = lmtc_pkg::mode_t'(stat_bits[1:0]);
            if (scan_line >= lmtc_pkg::VBLANK_FIRST)
            begin
                if (cur != lmtc_pkg::MODE_VBLANK)
                begin
                    enter_scan_mode(lmtc_pkg::MODE_VBLANK, lmtc_pkg::SRC_VBLANK,
                                    1'b1, 1'b1);
                    r.vblank_irq = 1'b1;
                    r.stat_irq   = 1'b1;
                end
                if (dot_cnt >= lmtc_pkg::DOTS_PER_LINE)
                begin
                    dot_cnt   = dot_cnt - lmtc_pkg::DOTS_PER_LINE;
                    scan_line = scan_line + 1'b1;
                end
                if (scan_line == lmtc_pkg::LINE_WRAP)
                begin
                    scan_line    = '0;
                    r.frame_done = 1'b1;
                end
            end
            else if (dot_cnt < lmtc_pkg::OAM_END)
            begin
                if (cur != lmtc_pkg::MODE_OAM)
                begin
                    enter_scan_mode(lmtc_pkg::MODE_OAM, lmtc_pkg::SRC_OAM, 1'b1, 1'b0);
                    r.stat_irq = 1'b1;
                end
            end
            else if (dot_cnt < lmtc_pkg::XFER_END)
            begin
                if (cur != lmtc_pkg::MODE_XFER)
                begin
                    enter_scan_mode(lmtc_pkg::MODE_XFER, lmtc_pkg::SRC_HBLANK,
                                    1'b0, 1'b0);
                    r.stat_irq     = 1'b1;
                    r.render_start = 1'b1;
                end
            end
            else if (dot_cnt < lmtc_pkg::DOTS_PER_LINE)
            begin
                if (cur != lmtc_pkg::MODE_HBLANK)
                begin
                    enter_scan_mode(lmtc_pkg::MODE_HBLANK, lmtc_pkg::SRC_HBLANK,
                                    1'b1, 1'b1);
                    r.stat_irq = 1'b1;
                end
            end
            else
            begin
                // visible line wrap, no mode entry on this tick
                dot_cnt   = dot_cnt - lmtc_pkg::DOTS_PER_LINE;
                scan_line = scan_line + 1'b1;
            end
        end
        r.line_number = scan_line;
        r.mode        = lmtc_pkg::mode_t'(stat_bits[1:0]);
        r.status_byte = stat_bits;
        r.vram_open   = vram_ok;
        r.oam_open    = oam_ok;
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in result %0d, %0s: expected %0d, got %0d",
                         n_results, label, want, got);
        end
    endtask

    task automatic add_tick(input logic [7:0] dots);
        plan_op_t op;
        op      = '{kind: OP_TICK, dots: dots, enable: 1'b0, idle_pct: 0, stall_pct: 0};
        tick_plan.push_back(op);
    endtask

    task automatic add_drain();
        plan_op_t op;
        op = '{kind: OP_DRAIN, dots: '0, enable: 1'b0, idle_pct: 0, stall_pct: 0};
        tick_plan.push_back(op);
    endtask

    task automatic add_enable(input logic value);
        plan_op_t op;
        add_drain();
        op = '{kind: OP_ENABLE, dots: '0, enable: value, idle_pct: 0, stall_pct: 0};
        tick_plan.push_back(op);
    endtask

    task automatic add_pace(input int unsigned idle, input int unsigned stall);
        plan_op_t op;
        op = '{kind: OP_PACE, dots: '0, enable: 1'b0, idle_pct: idle, stall_pct: stall};
        tick_plan.push_back(op);
    endtask

    // driver: ticks, register writes, pauses and pacing from the plan
    always @(negedge clk)
    begin
        logic                        next_valid;
        logic [lmtc_pkg::TICK_W-1:0] next_dots;
        logic                        next_cfg_valid;
        logic                        next_cfg_data;
        next_valid     = in_valid && !in_taken;
        next_dots      = elapsed_dots;
        next_cfg_valid = cfg_valid && !cfg_taken;
        next_cfg_data  = cfg_enable;
        if (rst_n)
        begin
            if (settle_left != 0)
                settle_left = settle_left - 1;
            else if (!next_valid && !next_cfg_valid && tick_plan.size() != 0)
            begin
                case (tick_plan[0].kind)
                    OP_TICK:
                    begin
                        if ($urandom_range(99) >= idle_pct)
                        begin
                            next_valid = 1'b1;
                            next_dots  = tick_plan[0].dots;
                            void'(tick_plan.pop_front());
                        end
                    end
                    OP_ENABLE:
                    begin
                        next_cfg_valid = 1'b1;
                        next_cfg_data  = tick_plan[0].enable;
                        void'(tick_plan.pop_front());
                    end
                    OP_DRAIN:
                    begin
                        if (scan_results_due.size() == 0)
                        begin
                            settle_left = DRAIN_SETTLE;
                            void'(tick_plan.pop_front());
                        end
                    end
                    OP_PACE:
                    begin
                        idle_pct  <= tick_plan[0].idle_pct;
                        stall_pct <= tick_plan[0].stall_pct;
                        void'(tick_plan.pop_front());
                    end
                endcase
            end
        end
        in_valid     <= next_valid;
        elapsed_dots <= next_dots;
        cfg_valid    <= next_cfg_valid;
        cfg_enable   <= next_cfg_data;
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // monitor: transfers seen at the rising edge
    always @(posedge clk)
    begin
        lmtc_pkg::result_t want;
        in_taken  <= rst_n && in_valid && !in_stall;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (scan_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no tick waiting", n_results);
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    check_field("line_number", want.line_number, line_number);
                    check_field("mode", want.mode, mode);
                    check_field("status_byte", want.status_byte, status_byte);
                    check_field("vram_open", want.vram_open, vram_open);
                    check_field("oam_open", want.oam_open, oam_open);
                    check_field("vblank_irq", want.vblank_irq, vblank_irq);
                    check_field("stat_irq", want.stat_irq, stat_irq);
                    check_field("render_start", want.render_start, render_start);
                    check_field("frame_done", want.frame_done, frame_done);
                    n_frames += want.frame_done;
                    n_vblank += want.vblank_irq;
                    n_render += want.render_start;
                end
            end
            if (cfg_valid && cfg_ready)
                display_on = cfg_enable;
            if (in_valid && !in_stall)
            begin
                if (!display_on)
                    n_dark++;
                advance_scan(elapsed_dots, want);
                scan_results_due.push_back(want);
                n_ticks++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, scan_results_due.size());
            $display("lcd_mode_timing_controller_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned phase_idle[4];
        int unsigned phase_stall[4];
        int unsigned pick;
        phase_idle  = '{0, 63, 0, 21};
        phase_stall = '{0, 0, 63, 21};

        // directed walk through the first lines and their boundaries
        add_pace(0, 0);
        add_enable(1'b1);
        add_tick(8'd0);
        add_tick(8'd79);
        add_tick(8'd1);
        add_tick(8'd172);
        add_tick(8'd1);
        add_tick(8'd202);
        add_tick(8'd1);
        add_tick(8'd0);
        add_tick(8'd255);
        add_tick(8'd255);
        add_tick(8'h55);
        add_tick(8'hAA);
        add_enable(1'b0);
        add_tick(8'd255);
        add_tick(8'd0);
        add_tick(8'h80);
        add_enable(1'b1);
        add_tick(8'd1);

        // random ticks, mostly large so that frames wrap
        for (int p = 0; p < 4; p++)
        begin
            add_drain();
            add_pace(phase_idle[p], phase_stall[p]);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                if (i == PHASE_TICKS / 2 && p >= 2)
                begin
                    add_enable(1'b0);
                    repeat (6) add_tick(8'($urandom_range(255)));
                    add_enable(1'b1);
                end
                pick = $urandom_range(9);
                case (pick) inside
                    0:       add_tick(8'd0);
                    1:       add_tick(8'($urandom_range(1, 40)));
                    2, 3:    add_tick(8'($urandom_range(255)));
                    default: add_tick(8'($urandom_range(180, 255)));
                endcase
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (tick_plan.size() != 0 || in_valid || cfg_valid
               || scan_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);

        $display("ran %0d ticks (%0d with display off), %0d results checked",
                 n_ticks, n_dark, n_results);
        $display("saw %0d frame wraps, %0d vblank entries, %0d render starts",
                 n_frames, n_vblank, n_render);
        if (mismatches == 0)
            $display("lcd_mode_timing_controller_tb passed");
        else
            $display("lcd_mode_timing_controller_tb failed");
        $finish;
    end

endmodule
